// ----- hw/rtl/esfs_pkg.sv -----
// shared constants, voigt index tables and controller/datapath link types
package esfs_pkg;

  localparam int VOIGT_COUNT     = 6;
  localparam int COEFS_PER_PHASE = 81;
  localparam int MACS_PER_RESULT = 9;

  localparam int VIDX_W   = 3;
  localparam int TIDX_W   = 4;
  localparam int PHASE_W  = 3;
  localparam int CIDX_W   = 7;
  localparam int CALC_AW  = 10;
  localparam int COEF_W   = 32;
  localparam int STRAIN_W = 32;
  localparam int EDIFF_W  = 33;
  localparam int PROD_W   = 65;
  localparam int ACC_W    = 68;
  localparam int STRESS_W = 64;

  localparam logic ACT_COEF   = 1'b0;
  localparam logic ACT_STRAIN = 1'b1;

  localparam logic [VIDX_W-1:0] VIDX_LAST = VIDX_W'(VOIGT_COUNT - 1);
  localparam logic [TIDX_W-1:0] TIDX_LAST = TIDX_W'(MACS_PER_RESULT - 1);

  typedef struct packed {
    logic              load_item;
    logic              mac_issue;
    logic              mac_first;
    logic [VIDX_W-1:0] vidx;
    logic [TIDX_W-1:0] tidx;
    logic              out_load;
  } esfs_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic out_take;
  } esfs_sts_t;

  // i*27 + j*9 for the row/column pair of a voigt stress component
  function automatic logic [CIDX_W-1:0] voigt_base(input logic [VIDX_W-1:0] v);
    logic [CIDX_W-1:0] b;
    case (v)
      3'd0:    b = 7'd0;
      3'd1:    b = 7'd36;
      3'd2:    b = 7'd72;
      3'd3:    b = 7'd45;
      3'd4:    b = 7'd18;
      3'd5:    b = 7'd9;
      default: b = 7'd0;
    endcase
    return b;
  endfunction

  // voigt strain index of term k*3+l
  function automatic logic [VIDX_W-1:0] strain_of(input logic [TIDX_W-1:0] t);
    logic [VIDX_W-1:0] s;
    case (t)
      4'd0:    s = 3'd0;
      4'd1:    s = 3'd5;
      4'd2:    s = 3'd4;
      4'd3:    s = 3'd5;
      4'd4:    s = 3'd1;
      4'd5:    s = 3'd3;
      4'd6:    s = 3'd4;
      4'd7:    s = 3'd3;
      4'd8:    s = 3'd2;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/esfs_if.sv -----
// valid/ready channel interfaces for input items and stress results
interface esfs_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic [2:0]         phase_id;
  logic [6:0]         coef_index;
  logic signed [31:0] coef_value;
  logic [2:0]         component;
  logic signed [31:0] strain_value;
  logic signed [31:0] eigen_value;
  logic               last_component;

  modport source (
    output valid, action, phase_id, coef_index, coef_value, component,
           strain_value, eigen_value, last_component,
    input  ready
  );
  modport sink (
    input  valid, action, phase_id, coef_index, coef_value, component,
           strain_value, eigen_value, last_component,
    output ready
  );
endinterface

interface esfs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         stress_component;
  logic signed [63:0] stress_value;
  logic               last_result;

  modport source (
    output valid, stress_component, stress_value, last_result,
    input  ready
  );
  modport sink (
    input  valid, stress_component, stress_value, last_result,
    output ready
  );
endinterface

// ----- hw/rtl/elastic_stress_from_strain.sv -----
// top level: per-point hooke's law stress from strain through a phase stiffness table
// Each input beat either writes one Q16.16 stiffness coefficient into the
// table of a material phase (action 0) or loads one Q1.30 strain component
// with its eigenstrain into the six-entry elastic strain buffer (action 1).
// The strain beat flagged last_component starts the contraction for that
// point's phase, which delivers six Q17.46 stress beats in voigt order
// xx,yy,zz,yz,xz,xy, each saturated to 64 bits, with last_result on the
// sixth. One shared 32x33 multiplier fed from the single-read-port stiffness
// memory does the nine multiply-accumulates of a result one per cycle; each
// product passes the memory read register and the product register before it
// reaches the accumulator, and the saturated sum is then registered for
// output. A result waits while the output register still holds the previous
// one. No input beat is taken during that computation. The stiffness table is
// PHASES*81 words and is not cleared at reset: every entry a point uses must
// be written first. A phase_id at or above PHASES gives all-zero stress and
// its coefficient writes are dropped.
module elastic_stress_from_strain #(
  parameter int PHASES = 8
) (
  input logic clk,
  input logic rst_n,
  esfs_in_if.sink    in_ch,
  esfs_out_if.source out_ch
);
  import esfs_pkg::*;

  esfs_cmd_t cmd;
  esfs_sts_t sts;
  logic      in_ready;
  logic      in_start;

  // a strain beat with last_component set kicks off the six results
  assign in_start    = (in_ch.action == ACT_STRAIN) && in_ch.last_component;
  assign in_ch.ready = in_ready;

  esfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_start (in_start),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  esfs_dp #(
    .PHASES (PHASES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_action            (in_ch.action),
    .in_phase_id          (in_ch.phase_id),
    .in_coef_index        (in_ch.coef_index),
    .in_coef_value        (in_ch.coef_value),
    .in_component         (in_ch.component),
    .in_strain_value      (in_ch.strain_value),
    .in_eigen_value       (in_ch.eigen_value),
    .out_valid            (out_ch.valid),
    .out_ready            (out_ch.ready),
    .out_stress_component (out_ch.stress_component),
    .out_stress_value     (out_ch.stress_value),
    .out_last_result      (out_ch.last_result)
  );

endmodule

// ----- hw/rtl/esfs_ctrl.sv -----
// sequencer: accepts beats, steps through the 9 mac terms of each of 6 results
module esfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_start,
  output logic                in_ready,
  input  esfs_pkg::esfs_sts_t sts,
  output esfs_pkg::esfs_cmd_t cmd
);
  import esfs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [VIDX_W-1:0] vidx_r, vidx_nxt;
  logic [TIDX_W-1:0] tidx_r, tidx_nxt;
  logic              drain_r, drain_nxt;
  logic              accept;
  logic              emit_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit_ok  = !sts.out_busy || sts.out_take;

  always_comb begin
    state_nxt     = state_r;
    vidx_nxt      = vidx_r;
    tidx_nxt      = tidx_r;
    drain_nxt     = drain_r;
    cmd.load_item = accept;
    cmd.mac_issue = 1'b0;
    cmd.mac_first = (tidx_r == '0);
    cmd.vidx      = vidx_r;
    cmd.tidx      = tidx_r;
    cmd.out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_start) begin
          state_nxt = ST_ISSUE;
          vidx_nxt  = '0;
          tidx_nxt  = '0;
        end
      end
      ST_ISSUE: begin
        cmd.mac_issue = 1'b1;
        if (tidx_r == TIDX_LAST) begin
          state_nxt = ST_DRAIN;
          drain_nxt = 1'b0;
        end else begin
          tidx_nxt = tidx_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_ok) begin
          cmd.out_load = 1'b1;
          tidx_nxt     = '0;
          if (vidx_r == VIDX_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            vidx_nxt  = vidx_r + 1'b1;
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vidx_r  <= '0;
      tidx_r  <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vidx_r  <= vidx_nxt;
      tidx_r  <= tidx_nxt;
      drain_r <= drain_nxt;
    end
  end

endmodule

// ----- hw/rtl/esfs_dp.sv -----
// datapath: stiffness memory, strain buffer, shared multiplier, accumulator, result register
module esfs_dp #(
  parameter int PHASES = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  esfs_pkg::esfs_cmd_t                   cmd,
  output esfs_pkg::esfs_sts_t                   sts,
  input  logic                                  in_action,
  input  logic [esfs_pkg::PHASE_W-1:0]          in_phase_id,
  input  logic [esfs_pkg::CIDX_W-1:0]           in_coef_index,
  input  logic signed [esfs_pkg::COEF_W-1:0]    in_coef_value,
  input  logic [esfs_pkg::VIDX_W-1:0]           in_component,
  input  logic signed [esfs_pkg::STRAIN_W-1:0]  in_strain_value,
  input  logic signed [esfs_pkg::STRAIN_W-1:0]  in_eigen_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [esfs_pkg::VIDX_W-1:0]           out_stress_component,
  output logic signed [esfs_pkg::STRESS_W-1:0]  out_stress_value,
  output logic                                  out_last_result
);
  import esfs_pkg::*;

  localparam int DEPTH = PHASES * COEFS_PER_PHASE;
  localparam int AW    = $clog2(DEPTH);

  logic signed [COEF_W-1:0]  mem [DEPTH];

  logic signed [EDIFF_W-1:0] ebuf_r [VOIGT_COUNT];
  logic signed [EDIFF_W-1:0] ediff;
  logic                      phase_in_ok;
  logic [CALC_AW-1:0]        phase_base;
  logic [CALC_AW-1:0]        wr_addr;
  logic [CALC_AW-1:0]        rd_addr;
  logic                      wr_en;
  logic                      strain_ld;

  logic [CALC_AW-1:0]        base_r;
  logic                      phase_ok_r;

  logic signed [COEF_W-1:0]  rdata_r;
  logic signed [EDIFF_W-1:0] sel_r;
  logic                      ok_s1_r;
  logic                      val_s1_r;
  logic                      first_s1_r;
  logic signed [COEF_W-1:0]  coef_m;

  logic signed [PROD_W-1:0]  prod_r;
  logic                      val_s2_r;
  logic                      first_s2_r;

  logic signed [ACC_W-1:0]   acc_r;
  logic signed [STRESS_W-1:0] sat;
  logic                      fits;

  logic                      out_valid_r;
  logic [VIDX_W-1:0]         out_comp_r;
  logic signed [STRESS_W-1:0] out_value_r;
  logic                      out_last_r;

  // input side
  assign phase_in_ok = int'(in_phase_id) < PHASES;
  assign phase_base  = CALC_AW'(in_phase_id) * CALC_AW'(COEFS_PER_PHASE);
  assign wr_addr     = phase_base + CALC_AW'(in_coef_index);
  assign wr_en       = cmd.load_item && (in_action == ACT_COEF) && phase_in_ok
                       && (int'(in_coef_index) < COEFS_PER_PHASE);
  assign strain_ld   = cmd.load_item && (in_action == ACT_STRAIN);
  assign ediff       = EDIFF_W'(in_strain_value) - EDIFF_W'(in_eigen_value);

  assign rd_addr = base_r + CALC_AW'(voigt_base(cmd.vidx)) + CALC_AW'(cmd.tidx);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(wr_addr)] <= in_coef_value;
    end
    if (cmd.mac_issue && phase_ok_r) begin
      rdata_r <= mem[AW'(rd_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < VOIGT_COUNT; e++) begin
        ebuf_r[e] <= '0;
      end
    end else if (strain_ld && (int'(in_component) < VOIGT_COUNT)) begin
      ebuf_r[in_component] <= ediff;
    end
  end

  always_ff @(posedge clk) begin
    if (strain_ld) begin
      base_r     <= phase_base;
      phase_ok_r <= phase_in_ok;
    end
    sel_r   <= ebuf_r[strain_of(cmd.tidx)];
    ok_s1_r <= phase_ok_r;
  end

  // multiply stage; out-of-range phase multiplies by zero
  assign coef_m = ok_s1_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    prod_r     <= PROD_W'(coef_m) * PROD_W'(sel_r);
    first_s1_r <= cmd.mac_first;
    first_s2_r <= first_s1_r;
    if (val_s2_r) begin
      acc_r <= (first_s2_r ? ACC_W'(0) : acc_r) + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_s1_r <= 1'b0;
      val_s2_r <= 1'b0;
    end else begin
      val_s1_r <= cmd.mac_issue;
      val_s2_r <= val_s1_r;
    end
  end

  // saturate the exact sum to 64 bits
  assign fits = (acc_r[ACC_W-1:STRESS_W-1] == '0) || (acc_r[ACC_W-1:STRESS_W-1] == '1);
  always_comb begin
    if (fits) begin
      sat = acc_r[STRESS_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sat = {1'b1, {(STRESS_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(STRESS_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_comp_r  <= cmd.vidx;
      out_value_r <= sat;
      out_last_r  <= (cmd.vidx == VIDX_LAST);
    end
  end

  assign sts.out_busy = out_valid_r;
  assign sts.out_take = out_valid_r && out_ready;

  assign out_valid            = out_valid_r;
  assign out_stress_component = out_comp_r;
  assign out_stress_value     = out_value_r;
  assign out_last_result      = out_last_r;

endmodule

// ----- tb/testbench.sv -----
// testbench for elastic_stress_from_strain: random and directed beats checked against a stress predictor
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import esfs_pkg::*;

  localparam int NUM_PHASES  = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int ROUND_BEATS = 85;

  // 68-bit limits used to saturate the exact nine-term sum
  localparam logic signed [67:0] STRESS_MAX = 68'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [67:0] STRESS_MIN = 68'shF_8000_0000_0000_0000;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // one input beat, every field carried even where the action ignores it
  typedef struct {
    logic               action;
    logic [2:0]         phase;
    logic [6:0]         cidx;
    logic signed [31:0] cval;
    logic [2:0]         comp;
    logic signed [31:0] strain;
    logic signed [31:0] eigen;
    logic               is_last;
  } in_beat_t;

  // one stress beat as it should leave the block
  typedef struct {
    logic [2:0]         comp;
    logic signed [63:0] value;
    logic               is_last;
  } stress_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  esfs_in_if  in_ch ();
  esfs_out_if out_ch ();

  elastic_stress_from_strain #(
    .PHASES(NUM_PHASES)
  ) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // beats waiting for the driver and stress beats waiting for the block
  in_beat_t     pending_beats[$];
  stress_beat_t stress_expected_q[$];

  // predictor state: phase stiffness words and the elastic strain buffer
  logic signed [31:0] stiff_mem [NUM_PHASES*COEFS_PER_PHASE];
  logic signed [32:0] elastic_strain [VOIGT_COUNT];

  // generator side: phases whose whole stiffness block has been written
  bit phase_loaded [NUM_PHASES];

  int send_idle_pct;
  int recv_idle_pct;
  bit hold_armed;
  bit hold_done;
  int hold_left;

  int beats_pushed;
  int beats_taken;
  int coef_writes;
  int points_done;
  int results_seen;
  int sat_count;
  int mismatches;
  int full_loads;

  in_beat_t     drv_beat;
  in_beat_t     mon_beat;
  stress_beat_t want;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // applies one accepted beat; a last strain beat queues six stress beats
  function automatic void hooke_take_beat(in_beat_t b);
    logic signed [67:0] acc;
    logic signed [67:0] coef_x;
    logic signed [67:0] strain_x;
    stress_beat_t       r;
    int                 row;
    int                 col;
    int                 addr;
    if (b.action == ACT_COEF) begin
      coef_writes++;
      // out-of-range phase or index: the write is dropped
      if (b.phase < NUM_PHASES && b.cidx < COEFS_PER_PHASE)
        stiff_mem[b.phase*COEFS_PER_PHASE + b.cidx] = b.cval;
      return;
    end
    // components 6 and 7 leave the buffer alone
    if (b.comp < VOIGT_COUNT)
      elastic_strain[b.comp] = {b.strain[31], b.strain} - {b.eigen[31], b.eigen};
    if (!b.is_last)
      return;
    points_done++;
    for (int v = 0; v < VOIGT_COUNT; v++) begin
      acc = '0;
      // stress row/col: xx,yy,zz then yz,xz,xy
      row = (v < 3) ? v : (v == 3) ? 1 : 0;
      col = (v < 3) ? v : (v == 5) ? 1 : 2;
      if (b.phase < NUM_PHASES) begin
        for (int k = 0; k < 3; k++) begin
          for (int l = 0; l < 3; l++) begin
            addr     = b.phase*COEFS_PER_PHASE + row*27 + col*9 + k*3 + l;
            coef_x   = 68'(stiff_mem[addr]);
            // off-diagonal (k,l) pairs fold onto voigt slot 6-k-l
            strain_x = 68'(elastic_strain[(k == l) ? k : 6 - k - l]);
            acc      = acc + coef_x * strain_x;
          end
        end
      end
      r.comp    = 3'(v);
      r.is_last = (v == VOIGT_COUNT - 1);
      if (acc > STRESS_MAX) begin
        r.value = STRESS_MAX[63:0];
        sat_count++;
      end else if (acc < STRESS_MIN) begin
        r.value = STRESS_MIN[63:0];
        sat_count++;
      end else begin
        r.value = acc[63:0];
      end
      stress_expected_q.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // strain or stiffness value: extremes, zero, small, or anything
  function automatic logic signed [31:0] pick_q();
    logic signed [31:0] x;
    case ($urandom_range(9))
      0:       x = Q_MAX;
      1:       x = Q_MIN;
      2:       x = '0;
      3, 4, 5: x = $urandom_range(2097151) - 1048576;
      default: x = $urandom;
    endcase
    return x;
  endfunction

  // all fields random so unused ones still toggle
  function automatic in_beat_t noise_beat();
    in_beat_t b;
    b.action  = 1'($urandom_range(1));
    b.phase   = 3'($urandom_range(7));
    b.cidx    = 7'($urandom_range(127));
    b.cval    = $urandom;
    b.comp    = 3'($urandom_range(7));
    b.strain  = $urandom;
    b.eigen   = $urandom;
    b.is_last = 1'($urandom_range(1));
    return b;
  endfunction

  task automatic push_coef(input int p, input int idx, input logic signed [31:0] val,
                           input bit lst);
    in_beat_t b;
    b         = noise_beat();
    b.action  = ACT_COEF;
    b.phase   = 3'(p);
    b.cidx    = 7'(idx);
    b.cval    = val;
    b.is_last = lst;
    pending_beats.push_back(b);
    beats_pushed++;
  endtask

  task automatic push_strain(input int p, input int c, input logic signed [31:0] s,
                             input logic signed [31:0] e, input bit lst);
    in_beat_t b;
    b         = noise_beat();
    b.action  = ACT_STRAIN;
    b.phase   = 3'(p);
    b.comp    = 3'(c);
    b.strain  = s;
    b.eigen   = e;
    b.is_last = lst;
    pending_beats.push_back(b);
    beats_pushed++;
  endtask

  // writes all 81 words of a phase, with dropped out-of-range writes mixed in
  task automatic load_phase(input int p, input bit all_min);
    for (int i = 0; i < COEFS_PER_PHASE; i++) begin
      if ($urandom_range(19) == 0)
        push_coef(p, $urandom_range(127, COEFS_PER_PHASE), pick_q(), 1'($urandom_range(1)));
      push_coef(p, i, all_min ? Q_MIN : pick_q(), 1'($urandom_range(1)));
    end
    phase_loaded[p] = 1'b1;
  endtask

  function automatic int loaded_phase();
    int p;
    do p = $urandom_range(NUM_PHASES - 1); while (!phase_loaded[p]);
    return p;
  endfunction

  // one point: shuffled components, sometimes a subset, sometimes closed by
  // an out-of-range component; only the closing beat's phase matters
  task automatic push_point(input int p);
    int  order [VOIGT_COUNT];
    int  n;
    int  j;
    int  tmp;
    bit  tail;
    for (int i = 0; i < VOIGT_COUNT; i++)
      order[i] = i;
    for (int i = VOIGT_COUNT - 1; i > 0; i--) begin
      j        = $urandom_range(i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    n    = ($urandom_range(4) == 0) ? $urandom_range(5, 1) : VOIGT_COUNT;
    tail = ($urandom_range(9) == 0);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1 && !tail)
        push_strain(p, order[i], pick_q(), pick_q(), 1'b1);
      else
        push_strain($urandom_range(7), order[i], pick_q(), pick_q(), 1'b0);
    end
    if (tail)
      push_strain(p, $urandom_range(7, 6), pick_q(), pick_q(), 1'b1);
  endtask

  task automatic random_step();
    int r;
    r = $urandom_range(99);
    if (r < 68) begin
      push_point(loaded_phase());
    end else if (r < 80) begin
      // rewrite of a word in use
      push_coef(loaded_phase(), $urandom_range(80), pick_q(), 1'($urandom_range(1)));
    end else if (r < 86) begin
      push_coef($urandom_range(7), $urandom_range(80), pick_q(), 1'($urandom_range(1)));
    end else if (r < 91) begin
      push_coef($urandom_range(7), $urandom_range(127, COEFS_PER_PHASE), pick_q(),
                1'($urandom_range(1)));
    end else if (r < 97) begin
      // stray strain beat that closes no point
      push_strain($urandom_range(7), $urandom_range(7), pick_q(), pick_q(), 1'b0);
    end else if (full_loads < 3) begin
      full_loads++;
      load_phase($urandom_range(6, 1), 1'b0);
    end else begin
      push_point(loaded_phase());
    end
  endtask

  task automatic random_part(input int n);
    int stop;
    stop = beats_pushed + n;
    while (beats_pushed < stop)
      random_step();
  endtask

  // every queued beat taken and every stress beat received
  task automatic wait_quiet();
    while (beats_taken != beats_pushed || stress_expected_q.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued beats, idles at random
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_beat             = pending_beats.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.action         <= drv_beat.action;
        in_ch.phase_id       <= drv_beat.phase;
        in_ch.coef_index     <= drv_beat.cidx;
        in_ch.coef_value     <= drv_beat.cval;
        in_ch.component      <= drv_beat.comp;
        in_ch.strain_value   <= drv_beat.strain;
        in_ch.eigen_value    <= drv_beat.eigen;
        in_ch.last_component <= drv_beat.is_last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // input monitor: every accepted beat goes through the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      mon_beat.action  = in_ch.action;
      mon_beat.phase   = in_ch.phase_id;
      mon_beat.cidx    = in_ch.coef_index;
      mon_beat.cval    = in_ch.coef_value;
      mon_beat.comp    = in_ch.component;
      mon_beat.strain  = in_ch.strain_value;
      mon_beat.eigen   = in_ch.eigen_value;
      mon_beat.is_last = in_ch.last_component;
      hooke_take_beat(mon_beat);
      beats_taken++;
    end
  end

  // long hold-off: once armed, the first stress beat freezes the receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_armed && !hold_done && out_ch.valid) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver: random stalls on top of the hold-off
  always @(posedge clk) begin
    if (!rst_n)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
  end

  // output monitor: compare against the oldest expected stress beat
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (stress_expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected stress beat comp=%0d value=%0d last=%0b", $time,
                 out_ch.stress_component, out_ch.stress_value, out_ch.last_result);
      end else begin
        want = stress_expected_q.pop_front();
        if (out_ch.stress_component !== want.comp) begin
          mismatches++;
          $display("%0t: stress_component expected %0d got %0d", $time,
                   want.comp, out_ch.stress_component);
        end
        if (out_ch.stress_value !== want.value) begin
          mismatches++;
          $display("%0t: stress_value (comp %0d) expected %0d got %0d", $time,
                   want.comp, want.value, out_ch.stress_value);
        end
        if (out_ch.last_result !== want.is_last) begin
          mismatches++;
          $display("%0t: last_result (comp %0d) expected %0b got %0b", $time,
                   want.comp, want.is_last, out_ch.last_result);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    logic signed [31:0] same;
    // known values on every input before the first edge
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.action         = ACT_COEF;
    in_ch.phase_id       = '0;
    in_ch.coef_index     = '0;
    in_ch.coef_value     = '0;
    in_ch.component      = '0;
    in_ch.strain_value   = '0;
    in_ch.eigen_value    = '0;
    in_ch.last_component = 1'b0;
    out_ch.ready         = 1'b0;
    for (int i = 0; i < VOIGT_COUNT; i++)
      elastic_strain[i] = '0;
    send_idle_pct = 18;
    recv_idle_pct = 86;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // round one: sender mostly busy, receiver mostly stalled
    // phase 0 random, phase 7 all most-negative so sums saturate
    load_phase(0, 1'b0);
    load_phase(7, 1'b1);

    // straight after reset only xx is delivered, the rest of the buffer is zero
    push_strain(7, 0, Q_MAX, Q_MIN, 1'b1);
    // largest positive elastic strain everywhere: negative saturation
    for (int v = 0; v < VOIGT_COUNT; v++)
      push_strain(7, v, Q_MAX, Q_MIN, v == VOIGT_COUNT - 1);
    // largest negative elastic strain, reverse order: positive saturation
    for (int v = VOIGT_COUNT - 1; v >= 0; v--)
      push_strain(7, v, Q_MIN, Q_MAX, v == 0);
    // dropped writes past index 80, then a real write carrying last_component
    push_coef(7, 127, Q_MAX, 1'b0);
    push_coef(0, COEFS_PER_PHASE, pick_q(), 1'b1);
    push_coef(7, 0, Q_MAX, 1'b1);
    // components 6 and 7 change nothing but the last one still computes
    push_strain(7, 6, pick_q(), pick_q(), 1'b0);
    push_strain(7, 7, pick_q(), pick_q(), 1'b1);
    // strain equal to eigenstrain: zero stress
    for (int v = 0; v < VOIGT_COUNT; v++) begin
      same = pick_q();
      push_strain(0, v, same, same, v == VOIGT_COUNT - 1);
    end
    // one lsb of xy strain, the rest kept from the previous point
    push_strain(0, 5, '0, -32'sd1, 1'b1);

    random_part(ROUND_BEATS);
    wait_quiet();

    // round two: sender mostly idle, receiver mostly ready
    send_idle_pct = 86;
    recv_idle_pct = 18;
    random_part(ROUND_BEATS);
    wait_quiet();

    // round three: no idling, one long receiver hold-off while beats keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_armed    = 1'b1;
    random_part(ROUND_BEATS);
    wait_quiet();

    // room for any stray beat after a full point computation
    repeat (150) @(posedge clk);

    $display("%0d input beats (%0d stiffness writes, %0d points), %0d stress beats checked",
             beats_taken, coef_writes, points_done, results_seen);
    $display("%0d saturated stress values, one %0d-cycle output hold-off under full load",
             sat_count, HOLD_CYCLES);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // watchdog far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("timeout: %0d beats taken of %0d, %0d stress beats outstanding",
             beats_taken, beats_pushed, stress_expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
